// ===== rtl/wheel_pulse_speed_meter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Wheel pulse speed meter - assertion macros
// Shared concurrent assertion forms, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef WHEEL_PULSE_SPEED_METER_CORE_MACROS_SVH
`define WHEEL_PULSE_SPEED_METER_CORE_MACROS_SVH

// Checked only while out of reset
`define WPSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every clock edge
`define WPSM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ===== rtl/wpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Wheel pulse speed meter - package
// Types, constants and helper functions shared by the meter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wpsm_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIMETER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 1'd1;

    localparam logic [15:0] PERIMETER_RESET = 16'd2045;
    localparam logic [15:0] WINDOW_RESET    = 16'd39900;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Item handed from the front to the back
    typedef struct packed {
        logic       rev;
        logic       done;
        logic [7:0] revs;
    } t_front_item;

    typedef struct packed {
        logic                full;
        logic                empty;
        logic [QUEUE_CW-1:0] count;
    } t_queue_status;

    // Divide by 43: floor(2^22 / 43), result at most one short
    localparam logic [16:0] DIV43_MUL   = 17'd97541;
    localparam int          DIV43_SHIFT = 22;
    localparam logic [15:0] DIV43       = 16'd43;
    localparam int          Q43_W       = 11;

    // Divide by 500: floor(2^25 / 500), result at most one short
    localparam logic [16:0] DIV500_MUL   = 17'd67108;
    localparam int          DIV500_SHIFT = 25;
    localparam logic [23:0] DIV500       = 24'd500;
    localparam int          Q500_W       = 16;

    localparam logic [7:0]  SPEED_MAX    = 8'd255;
    localparam logic [15:0] ELAPSED_STEP = 16'd5;

    // Active-low ABCDEFG.dp patterns for 0..9
    localparam logic [7:0] SEG_CODES [10] = '{
        8'h03, 8'h9f, 8'h25, 8'h0d, 8'h99, 8'h49, 8'h41, 8'h1f, 8'h01, 8'h09
    };
    localparam logic [7:0] SEG_BLANK = 8'hff;
    localparam logic [3:0] DIGIT_LIMIT = 4'd10;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        code = SEG_BLANK;
        if (digit < DIGIT_LIMIT) begin
            code = SEG_CODES[digit];
        end
        return code;
    endfunction

    // {tens, units} segment codes of speed / 2
    function automatic logic [15:0] speed_segments(input logic [7:0] speed);
        logic [6:0]  half;
        logic [14:0] scaled;
        logic [3:0]  tens;
        logic [6:0]  units;
        half   = speed[7:1];
        // x * 205 >> 11 is x / 10 for x below 1029
        scaled = half * 8'd205;
        tens   = scaled[14:11];
        units  = half - 7'({3'd0, tens} * 7'd10);
        return {seg_code(tens), seg_code(units[3:0])};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wpsm_front.sv =====
// ----------------------------------------------------------------------------
// Wheel pulse speed meter - front end
// Moving-sum filter, revolution edge detect and window tick counter.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsm_front #(
    parameter int FILTER_TAPS = 8
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire                      i_sensor_level,
    input  wire  [15:0]              i_window_ticks,
    input  wire                      i_queue_full,
    output logic                     o_push,
    output wpsm_pkg::t_front_item    o_item
);
    import wpsm_pkg::*;

    logic [FILTER_TAPS-1:0] r_hist;
    logic [FILTER_TAPS-1:0] n_hist;
    logic                   r_prev_pulse;
    logic [7:0]             r_revs;
    logic [15:0]            r_ticks;

    logic        accept;
    logic        pulse;
    logic        rev;
    logic        done;
    logic [15:0] ticks_inc;
    logic [7:0]  revs_inc;

    // Classify the item: the moving sum drops exactly when a 1 leaves
    // the window and a 0 comes in, which gives a pulse
    always_comb begin
        accept    = i_in_valid && !i_queue_full;
        n_hist    = {r_hist[FILTER_TAPS-2:0], i_sensor_level};
        pulse     = r_hist[FILTER_TAPS-1] & ~i_sensor_level;
        rev       = pulse & ~r_prev_pulse;
        revs_inc  = r_revs + {7'd0, rev};
        ticks_inc = r_ticks + 16'd1;
        done      = (ticks_inc == i_window_ticks);
    end

    assign o_in_stall = i_queue_full;
    assign o_push     = accept;
    assign o_item     = '{rev: rev, done: done, revs: revs_inc};

    // Front state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist       <= '0;
            r_prev_pulse <= 1'b0;
            r_revs       <= '0;
            r_ticks      <= '0;
        end else if (accept) begin
            r_hist       <= n_hist;
            r_prev_pulse <= pulse;
            r_revs       <= done ? 8'd0 : revs_inc;
            r_ticks      <= done ? 16'd0 : ticks_inc;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wpsm_queue.sv =====
// ----------------------------------------------------------------------------
// Wheel pulse speed meter - item queue
// Small register FIFO decoupling the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsm_queue (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_push,
    input  wire wpsm_pkg::t_front_item i_item,
    input  wire                       i_pop,
    output wpsm_pkg::t_front_item     o_head,
    output wpsm_pkg::t_queue_status   o_status
);
    import wpsm_pkg::*;

    t_front_item         r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= QUEUE_AW'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= QUEUE_AW'(r_rd_ptr + 1'b1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= QUEUE_CW'(r_count + 1'b1);
                2'b01:   r_count <= QUEUE_CW'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wpsm_back.sv =====
// ----------------------------------------------------------------------------
// Wheel pulse speed meter - back end
// Window arithmetic pipeline, trip state and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsm_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire wpsm_pkg::t_front_item i_head,
    input  wire                    i_queue_empty,
    output logic                   o_pop,
    input  wire  [15:0]            i_perimeter,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output logic                   o_rev_pulse,
    output logic                   o_window_done,
    output logic [7:0]             o_speed_value,
    output logic [7:0]             o_tens_segments,
    output logic [7:0]             o_units_segments,
    output logic [15:0]            o_distance_m,
    output logic [15:0]            o_elapsed_s
);
    import wpsm_pkg::*;

    logic en;

    // Stage 1: perimeter * revolutions
    logic        r_s1_vld;
    logic        r_s1_rev;
    logic        r_s1_done;
    logic [23:0] r_s1_prod;

    // Stage 2: reciprocal products
    logic        r_s2_vld;
    logic        r_s2_rev;
    logic        r_s2_done;
    logic [23:0] r_s2_prod;
    logic [32:0] r_s2_p43;
    logic [40:0] r_s2_p500;

    // Stage 3: corrected quotients
    logic              r_s3_vld;
    logic              r_s3_rev;
    logic              r_s3_done;
    logic [Q43_W-1:0]  r_s3_q43;
    logic [Q500_W-1:0] r_s3_q500;

    // Stage 4: trip state after this item
    logic        r_s4_vld;
    logic        r_s4_rev;
    logic        r_s4_done;
    logic [7:0]  r_speed;
    logic [15:0] r_distance;
    logic [15:0] r_elapsed;

    // Result register
    logic        r_out_vld;
    logic        r_out_rev;
    logic        r_out_done;
    logic [7:0]  r_out_speed;
    logic [15:0] r_out_segs;
    logic [15:0] r_out_distance;
    logic [15:0] r_out_elapsed;

    logic [15:0]       speed_num;
    logic [Q43_W-1:0]  q43_est;
    logic [15:0]       rem43;
    logic [Q500_W-1:0] q500_est;
    logic [23:0]       rem500;
    logic [7:0]        speed_sat;

    // Whole pipeline moves unless the result register is held
    assign en    = !r_out_vld || !i_out_stall;
    assign o_pop = en && !i_queue_empty;

    // Quotient correction: estimates are exact or one short
    always_comb begin
        speed_num = r_s2_prod[19:4];
        q43_est   = r_s2_p43[DIV43_SHIFT +: Q43_W];
        rem43     = speed_num - 16'(q43_est * DIV43);
        q500_est  = r_s2_p500[DIV500_SHIFT +: Q500_W];
        rem500    = r_s2_prod - 24'(q500_est * DIV500);
        speed_sat = (r_s3_q43 > Q43_W'(SPEED_MAX)) ? SPEED_MAX : r_s3_q43[7:0];
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld  <= o_pop;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_out_vld <= r_s4_vld;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_rev  <= i_head.rev;
            r_s1_done <= i_head.done;
            r_s1_prod <= i_perimeter * i_head.revs;

            r_s2_rev  <= r_s1_rev;
            r_s2_done <= r_s1_done;
            r_s2_prod <= r_s1_prod;
            r_s2_p43  <= r_s1_prod[19:4] * DIV43_MUL;
            r_s2_p500 <= r_s1_prod * DIV500_MUL;

            r_s3_rev  <= r_s2_rev;
            r_s3_done <= r_s2_done;
            r_s3_q43  <= q43_est + Q43_W'(rem43 >= DIV43);
            r_s3_q500 <= q500_est + Q500_W'(rem500 >= DIV500);

            r_s4_rev  <= r_s3_rev;
            r_s4_done <= r_s3_done;

            r_out_rev      <= r_s4_rev;
            r_out_done     <= r_s4_done;
            r_out_speed    <= r_speed;
            r_out_segs     <= speed_segments(r_speed);
            r_out_distance <= r_distance;
            r_out_elapsed  <= r_elapsed;
        end
    end

    // Trip state, updated as a window-closing item passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed    <= '0;
            r_distance <= '0;
            r_elapsed  <= '0;
        end else if (en && r_s3_vld && r_s3_done) begin
            r_speed    <= speed_sat;
            r_distance <= r_distance + r_s3_q500;
            r_elapsed  <= r_elapsed + ELAPSED_STEP;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_rev_pulse      = r_out_rev;
    assign o_window_done    = r_out_done;
    assign o_speed_value    = r_out_speed;
    assign o_tens_segments  = r_out_segs[15:8];
    assign o_units_segments = r_out_segs[7:0];
    assign o_distance_m     = r_out_distance;
    assign o_elapsed_s      = r_out_elapsed;

endmodule

`default_nettype wire

// ===== rtl/wheel_pulse_speed_meter_core.sv =====
// ----------------------------------------------------------------------------
// Wheel pulse speed meter - top level
// Sensor filter, revolution counter, windowed speed, distance and time.
// ----------------------------------------------------------------------------
// One sensor sample is taken per cycle unless the input is stalled, and
// each sample gives exactly one result item. The front end classifies a
// sample in the cycle it is taken (filter, revolution edge, window count)
// and pushes it into a 4-entry queue; a 4-stage back end (product,
// reciprocal multiply, quotient correction, trip state) then feeds a
// result register. The input stalls only while the queue is full, which
// happens only after the output has been stalled. No clearing pass after
// reset.
`default_nettype none

module wheel_pulse_speed_meter_core #(
    parameter int FILTER_TAPS = 8
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // Configuration
    input  wire                         i_cfg_we,
    input  wire  [wpsm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [15:0]                 i_cfg_data,
    // Input items
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire                         i_sensor_level,
    // Result items
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic                        o_rev_pulse,
    output logic                        o_window_done,
    output logic [7:0]                  o_speed_value,
    output logic [7:0]                  o_tens_segments,
    output logic [7:0]                  o_units_segments,
    output logic [15:0]                 o_distance_m,
    output logic [15:0]                 o_elapsed_s
);
    import wpsm_pkg::*;

    `include "wheel_pulse_speed_meter_core_macros.svh"

    logic [15:0] r_perimeter;
    logic [15:0] r_window;

    logic          q_push;
    logic          q_pop;
    t_front_item   q_in;
    t_front_item   q_head;
    t_queue_status q_status;

    // Queue bookkeeping seen by the checks
    logic                lone_push;
    logic [QUEUE_CW-1:0] q_count;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perimeter <= PERIMETER_RESET;
            r_window    <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PERIMETER: r_perimeter <= i_cfg_data;
                REG_WINDOW:    r_window    <= i_cfg_data;
                default:       r_perimeter <= r_perimeter;
            endcase
        end
    end

    wpsm_front #(
        .FILTER_TAPS (FILTER_TAPS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sensor_level (i_sensor_level),
        .i_window_ticks (r_window),
        .i_queue_full   (q_status.full),
        .o_push         (q_push),
        .o_item         (q_in)
    );

    wpsm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (q_in),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    wpsm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (q_head),
        .i_queue_empty    (q_status.empty),
        .o_pop            (q_pop),
        .i_perimeter      (r_perimeter),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_rev_pulse      (o_rev_pulse),
        .o_window_done    (o_window_done),
        .o_speed_value    (o_speed_value),
        .o_tens_segments  (o_tens_segments),
        .o_units_segments (o_units_segments),
        .o_distance_m     (o_distance_m),
        .o_elapsed_s      (o_elapsed_s)
    );

    assign lone_push = i_rst_n && q_push && !q_pop;
    assign q_count   = q_status.count;

    // Back end never takes from an empty queue
    `WPSM_ASSERT(a_pop_nonempty, q_pop |-> !q_status.empty, "pop from empty queue")

    // A lone push grows the fill count by one
    `WPSM_ASSERT(a_count_push, $past(lone_push) |-> q_count == $past(q_count) + 1'b1, "lost push")

    // Units digit of speed / 2 is always a real digit
    `WPSM_ASSERT(a_units_digit, o_out_valid |-> o_units_segments != SEG_BLANK, "units digit blank")

endmodule

`default_nettype wire
